### hdl/assert_macros.svh
// Assertion macros shared by the flight phase detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define FPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define FPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FPD_ASSERT(lbl, prop, msg)
`define FPD_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### hdl/fpd_pkg.sv
// Types, constants and register defaults for the flight phase detector.
package fpd_pkg;

  localparam int WINDOW_DEF = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int CNT_W      = 12;
  localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;

  localparam logic [15:0] THR_RST     = 16'd3014;
  localparam logic [9:0]  BURN_RST    = 10'd42;
  localparam logic [22:0] DEPLOY_RST  = 23'd38100;
  localparam logic [11:0] APOGEE_RST  = 12'd10;
  localparam logic [11:0] LANDING_RST = 12'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAUNCH_THR  = 3'd0,
    REG_BURN        = 3'd1,
    REG_DEPLOY_ALT  = 3'd2,
    REG_APOGEE      = 3'd3,
    REG_LANDING     = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_PAD     = 3'd0,
    PH_BURN    = 3'd1,
    PH_ASCENT  = 3'd2,
    PH_COAST   = 3'd3,
    PH_DESCENT = 3'd4,
    PH_LANDED  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_LAUNCH  = 3'd1,
    EV_BURNOUT = 3'd2,
    EV_DEPLOY  = 3'd3,
    EV_APOGEE  = 3'd4,
    EV_LANDING = 3'd5
  } event_t;

  typedef struct packed {
    logic [15:0]        accel_magnitude;
    logic signed [23:0] altitude;
  } fpd_in_t;

  typedef struct packed {
    phase_t phase;
    event_t event_res;
    logic   primary_deployed;
    logic   secondary_deployed;
  } fpd_out_t;

  typedef struct packed {
    logic [15:0] launch_threshold;
    logic [9:0]  burn_samples;
    logic [22:0] deploy_altitude;
    logic [11:0] apogee_samples;
    logic [11:0] landing_samples;
  } fpd_cfg_t;

endpackage

### hdl/rocket_flight_phase_detector_unit.sv
// Output: the result of each accepted item is registered into the output register.
// Throughput: one item per cycle unless the output is stalled; the window RAM
// reads ahead at the slot the next pad item replaces, so its read never stalls input.
// Reset: registers to defaults, phase pad; window slots read as zero until
// written (per-slot valid bits), so no clearing pass is needed.
`include "assert_macros.svh"
module rocket_flight_phase_detector_unit import fpd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fpd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fpd_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fpd_cfg_t cfg_r;
  logic     accept, advance, launch_hit;
  fpd_out_t result, out_data_r;
  logic     out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.launch_threshold <= THR_RST;
      cfg_r.burn_samples     <= BURN_RST;
      cfg_r.deploy_altitude  <= DEPLOY_RST;
      cfg_r.apogee_samples   <= APOGEE_RST;
      cfg_r.landing_samples  <= LANDING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LAUNCH_THR: cfg_r.launch_threshold <= cfg_data[15:0];
        REG_BURN:       cfg_r.burn_samples     <= cfg_data[9:0];
        REG_DEPLOY_ALT: cfg_r.deploy_altitude  <= cfg_data;
        REG_APOGEE:     cfg_r.apogee_samples   <= cfg_data[11:0];
        REG_LANDING:    cfg_r.landing_samples  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  fpd_window #(.WINDOW(WINDOW)) u_window (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .accel            (in_data.accel_magnitude),
    .launch_threshold (cfg_r.launch_threshold),
    .launch_hit       (launch_hit)
  );

  fpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (in_data),
    .cfg        (cfg_r),
    .launch_hit (launch_hit),
    .advance    (advance),
    .result     (result)
  );

  // output register; refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  `FPD_ASSERT_IMP(a_stall_needs_item, in_stall, out_valid_r, "input stalled with empty output register")
  `FPD_ASSERT_IMP(a_launch_to_burn, out_valid_r && (out_data_r.event_res == EV_LAUNCH), out_data_r.phase == PH_BURN, "launch item not in burn phase")
  `FPD_ASSERT_IMP(a_fins_order, out_valid_r && out_data_r.secondary_deployed, out_data_r.primary_deployed, "secondary fins before primary")
  `FPD_ASSERT_IMP(a_held_on_stall, out_valid_r && out_stall, ##1 (out_valid_r && $stable(out_data_r)), "stalled result changed")

endmodule

### hdl/fpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module fpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fpd_window.sv
// Acceleration window: sample RAM, running sum and launch threshold compare.
module fpd_window import fpd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic [15:0] accel,
  input  logic [15:0] launch_threshold,
  output logic        launch_hit
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = $clog2(65535 * WINDOW + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic [PTR_W-1:0]  ptr_r, ptr_nxt, ptr_inc;
  logic [SUM_W-1:0]  sum_r, sum_new, thr_win;
  logic [WINDOW-1:0] vld_r;
  logic              fwd_hit_r;
  logic [15:0]       fwd_data_r;
  logic [15:0]       ram_rd, old_raw, old_val;

  // read-ahead: RAM always fetches the slot the next item will replace
  fpd_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_ram (
    .clk   (clk),
    .we    (advance),
    .waddr (ptr_r),
    .wdata (accel),
    .raddr (ptr_nxt),
    .rdata (ram_rd)
  );

  assign ptr_inc = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
  assign ptr_nxt = advance ? ptr_inc : ptr_r;

  // slot written last cycle and read again now (single-entry window)
  assign old_raw = fwd_hit_r ? fwd_data_r : ram_rd;
  assign old_val = vld_r[ptr_r] ? old_raw : 16'd0;

  assign sum_new    = sum_r - SUM_W'(old_val) + SUM_W'(accel);
  assign thr_win    = SUM_W'(SUM_W'(launch_threshold) * SUM_W'(WINDOW));
  assign launch_hit = (sum_new >= thr_win);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      sum_r     <= '0;
      vld_r     <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      ptr_r     <= ptr_nxt;
      fwd_hit_r <= advance && (ptr_nxt == ptr_r);
      if (advance) begin
        sum_r        <= sum_new;
        vld_r[ptr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= accel;
  end

endmodule

### hdl/fpd_ctrl.sv
// Flight phase state machine with sample counter and altitude extreme tracking.
module fpd_ctrl import fpd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  fpd_in_t  item,
  input  fpd_cfg_t cfg,
  input  logic     launch_hit,
  output logic     advance,
  output fpd_out_t result
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt, cnt_inc, coast_cnt, desc_cnt;
  logic signed [23:0] extreme_r, extreme_nxt;
  logic               min_seen_r, min_seen_nxt;
  logic               burn_hit, deploy_hit, new_max, apogee_hit, new_min, land_hit;
  event_t             ev;

  assign cnt_inc    = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign burn_hit   = (cnt_inc >= CNT_W'(cfg.burn_samples));
  assign deploy_hit = (item.altitude >= $signed({1'b0, cfg.deploy_altitude}));
  assign new_max    = (item.altitude >= extreme_r);
  assign coast_cnt  = new_max ? '0 : cnt_inc;
  assign apogee_hit = (coast_cnt >= cfg.apogee_samples);
  assign new_min    = !min_seen_r || (item.altitude < extreme_r);
  assign desc_cnt   = new_min ? '0 : cnt_inc;
  assign land_hit   = (desc_cnt >= cfg.landing_samples);

  assign advance = accept && (phase_r == PH_PAD);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_PAD:     if (launch_hit) phase_nxt = PH_BURN;
        PH_BURN:    if (burn_hit)   phase_nxt = PH_ASCENT;
        PH_ASCENT:  if (deploy_hit) phase_nxt = PH_COAST;
        PH_COAST:   if (apogee_hit) phase_nxt = PH_DESCENT;
        PH_DESCENT: if (land_hit)   phase_nxt = PH_LANDED;
        default:    phase_nxt = PH_LANDED;
      endcase
    end
  end

  // event and datapath updates
  always_comb begin
    ev           = EV_NONE;
    count_nxt    = count_r;
    extreme_nxt  = extreme_r;
    min_seen_nxt = min_seen_r;
    if (accept) begin
      unique case (phase_r)
        PH_PAD: begin
          if (launch_hit) begin
            ev        = EV_LAUNCH;
            count_nxt = '0;
          end
        end
        PH_BURN: begin
          count_nxt = burn_hit ? '0 : cnt_inc;
          if (burn_hit) ev = EV_BURNOUT;
        end
        PH_ASCENT: begin
          if (deploy_hit) begin
            ev          = EV_DEPLOY;
            count_nxt   = '0;
            extreme_nxt = '0;
          end
        end
        PH_COAST: begin
          if (apogee_hit) begin
            ev           = EV_APOGEE;
            count_nxt    = '0;
            extreme_nxt  = '0;
            min_seen_nxt = 1'b0;
          end else begin
            count_nxt = coast_cnt;
            if (new_max) extreme_nxt = item.altitude;
          end
        end
        PH_DESCENT: begin
          count_nxt = desc_cnt;
          if (new_min) begin
            extreme_nxt  = item.altitude;
            min_seen_nxt = 1'b1;
          end
          if (land_hit) ev = EV_LANDING;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.phase              = phase_nxt;
    result.event_res          = ev;
    result.primary_deployed   = (phase_nxt >= PH_COAST);
    result.secondary_deployed = (phase_nxt >= PH_DESCENT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PAD;
      count_r    <= '0;
      extreme_r  <= '0;
      min_seen_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      extreme_r  <= extreme_nxt;
      min_seen_r <= min_seen_nxt;
    end
  end

endmodule
